### sv/huffman_tree_stream_decoder_defines.svh
// assertion macros shared by the decoder modules
`ifndef HUFFMAN_TREE_STREAM_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_STREAM_DECODER_DEFINES_SVH

// condition holds at every edge out of reset
`define HTS_ASSERT_TRUE(lbl, c, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (c)) else $error(msg);

// consequence holds in the same cycle
`define HTS_ASSERT_IMPL(lbl, a, c, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// consequence holds in the next cycle
`define HTS_ASSERT_NEXT(lbl, a, c, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

### sv/hts_pkg.sv
`default_nettype none
package hts_pkg;

    localparam int MAX_NODES   = 512;
    localparam int STACK_DEPTH = 256;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int NC_W        = $clog2(MAX_NODES + 1);
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int LEAF_BITS   = 8;

    // register indexes of the configuration port
    localparam logic [7:0] CFG_TREE = 8'd0;
    localparam logic [7:0] CFG_DATA = 8'd1;
    localparam logic [7:0] CFG_CAP  = 8'd2;

    // status codes
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_SIZE = 3'd1;
    localparam logic [2:0] ST_OVF  = 3'd2;
    localparam logic [2:0] ST_INC  = 3'd3;
    localparam logic [2:0] ST_MAL  = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TOKEN,
        PH_BRACKET,
        PH_LEAF,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0]        value;
        logic [NODE_W-1:0] first;
        logic [NODE_W-1:0] last;
    } node_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] first;
    } stk_t;

    typedef struct packed {
        logic [7:0]  symbol;
        logic        symbol_valid;
        logic        done_res;
        logic [2:0]  status;
        logic [31:0] out_count;
    } result_t;

endpackage
`default_nettype wire

### sv/hts_out_fifo.sv
`default_nettype none
`include "huffman_tree_stream_decoder_defines.svh"
module hts_out_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hts_pkg::result_t push_data,
    output logic                 room,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output hts_pkg::result_t     out_data
);
    import hts_pkg::*;

    result_t    slot_reg [2];
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign room      = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    `HTS_ASSERT_TRUE(a_count_range, count_reg <= 2'd2, "output queue count out of range")
    `HTS_ASSERT_IMPL(a_no_overrun, push && count_reg == 2'd2, pop, "push into a full queue")
    `HTS_ASSERT_NEXT(a_push_shows, push && count_reg == 2'd0, out_valid, "pushed item not shown")

endmodule
`default_nettype wire

### sv/hts_core.sv
`default_nettype none
`include "huffman_tree_stream_decoder_defines.svh"
module hts_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic             bit_in,
    input  wire logic             first,
    input  wire logic             cfg_we,
    input  wire logic [7:0]       cfg_index,
    input  wire logic [31:0]      cfg_data,
    output logic                  busy,
    output logic                  push,
    output hts_pkg::result_t      res
);
    import hts_pkg::*;

    // memories
    node_t node_mem [MAX_NODES];
    stk_t  stk_mem  [STACK_DEPTH];
    node_t node_rdata_reg;
    stk_t  stk_rdata_reg;

    // configuration
    logic [31:0] tree_cnt_reg, data_cnt_reg, cap_reg;

    // control and walk state
    phase_t            phase_reg, phase_next, ph_cur;
    logic [SP_W-1:0]   sp_reg, sp_next, sp_m1, sp_m2;
    logic [NC_W-1:0]   nc_reg, nc_next;
    logic [32:0]       bits_reg, bits_next;
    logic [7:0]        sh_reg, sh_next;
    logic [2:0]        idx_reg, idx_next;
    logic [31:0]       bytes_reg, bytes_next;
    stk_t              top_reg, top_next;
    logic              top_load_reg, top_load_next;
    logic [NODE_W-1:0] rf_reg, rf_next, sf_reg, sf_next, sl_reg, sl_next;
    logic [NODE_W-1:0] cf_reg, cf_next, cl_reg, cl_next;
    logic              busy_reg, busy_next;
    logic [NODE_W-1:0] rd_addr_reg, rd_addr_next;
    logic              fwd_hit_reg, fwd_hit_next;
    node_t             fwd_data_reg, fwd_data_next;
    logic              pend_we_reg, pend_we_next;
    logic [NODE_W-1:0] pend_addr_reg, pend_addr_next;
    node_t             pend_data_reg, pend_data_next;

    // write ports and step flags
    logic              add_we;
    logic [NODE_W-1:0] add_addr;
    node_t             add_data;
    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    node_t             mem_wdata;
    logic              stk_we;
    logic [STK_AW-1:0] stk_waddr, stk_raddr;
    stk_t              stk_wdata;
    logic              do_add, add_push, add_fail, chk_tok, chk_end;
    logic [7:0]        add_val;
    logic [NODE_W-1:0] new_node, par_first;
    logic              stop_f, sym_v;
    logic [2:0]        stop_st;
    logic [7:0]        sym;
    node_t             rec;

    assign busy   = busy_reg;
    assign ph_cur = first ? PH_TOKEN : phase_reg;
    assign sp_m1  = sp_reg - SP_W'(1);
    assign sp_m2  = sp_reg - SP_W'(2);
    assign rec    = fwd_hit_reg ? fwd_data_reg : node_rdata_reg;

    // one bit step: tree build on accept, node lookup result in the next cycle
    always_comb
    begin
        phase_next     = phase_reg;
        sp_next        = sp_reg;
        nc_next        = nc_reg;
        bits_next      = bits_reg;
        sh_next        = sh_reg;
        idx_next       = idx_reg;
        bytes_next     = bytes_reg;
        top_next       = top_load_reg ? stk_rdata_reg : top_reg;
        top_load_next  = 1'b0;
        rf_next        = rf_reg;
        sf_next        = sf_reg;
        sl_next        = sl_reg;
        cf_next        = cf_reg;
        cl_next        = cl_reg;
        busy_next      = 1'b0;
        rd_addr_next   = rd_addr_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_data_next  = fwd_data_reg;
        pend_we_next   = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_data_next = pend_data_reg;
        add_we         = 1'b0;
        add_addr       = '0;
        add_data       = '0;
        stk_we         = 1'b0;
        stk_waddr      = '0;
        stk_wdata      = '0;
        stk_raddr      = '0;
        do_add         = 1'b0;
        add_push       = 1'b0;
        add_fail       = 1'b0;
        add_val        = '0;
        new_node       = '0;
        par_first      = '0;
        chk_tok        = 1'b0;
        chk_end        = 1'b0;
        stop_f         = 1'b0;
        stop_st        = ST_OK;
        sym_v          = 1'b0;
        sym            = '0;

        if (busy_reg)
        begin
            // data bit, after the lookup: node record is here
            bits_next = bits_reg + 33'd1;
            if (rec.first == '0)
            begin
                if (bytes_reg >= cap_reg)
                begin
                    stop_f  = 1'b1;
                    stop_st = ST_OVF;
                end
                else
                begin
                    sym_v      = 1'b1;
                    sym        = rec.value;
                    bytes_next = bytes_reg + 32'd1;
                    cf_next    = sf_reg;
                    cl_next    = sl_reg;
                end
            end
            else
            begin
                cf_next = rec.first;
                cl_next = rec.last;
            end
            if (!stop_f && bits_next >= {1'b0, data_cnt_reg})
            begin
                stop_f  = 1'b1;
                stop_st = (rec.first == '0) ? ST_OK : ST_INC;
            end
        end
        else if (in_fire)
        begin
            // new stream clears the tree
            if (first)
            begin
                sp_next    = SP_W'(1);
                nc_next    = NC_W'(1);
                bits_next  = '0;
                sh_next    = '0;
                idx_next   = '0;
                bytes_next = '0;
                top_next   = '0;
                rf_next    = '0;
                sf_next    = '0;
                sl_next    = '0;
                phase_next = PH_TOKEN;
                if (tree_cnt_reg == 32'd0)
                    chk_end = 1'b1;
            end
            if (!chk_end)
            begin
                unique case (ph_cur)
                    PH_TOKEN:
                    begin
                        bits_next  = bits_next + 33'd1;
                        phase_next = bit_in ? PH_LEAF : PH_BRACKET;
                        sh_next    = '0;
                        idx_next   = '0;
                    end
                    PH_BRACKET:
                    begin
                        bits_next  = bits_next + 33'd1;
                        phase_next = PH_TOKEN;
                        if (bit_in)
                        begin
                            if (sp_reg != '0)
                                sp_next = sp_m1;
                            if (sp_reg >= SP_W'(2))
                            begin
                                stk_raddr     = sp_m2[STK_AW-1:0];
                                top_load_next = 1'b1;
                            end
                            chk_tok = 1'b1;
                        end
                        else
                        begin
                            do_add   = 1'b1;
                            add_push = 1'b1;
                        end
                    end
                    PH_LEAF:
                    begin
                        bits_next = bits_next + 33'd1;
                        sh_next   = {sh_reg[LEAF_BITS-2:0], bit_in};
                        if (idx_reg == 3'(LEAF_BITS - 1))
                        begin
                            idx_next   = '0;
                            phase_next = PH_TOKEN;
                            do_add     = 1'b1;
                            add_val    = sh_next;
                        end
                        else
                            idx_next = idx_reg + 3'd1;
                    end
                    PH_DATA:
                    begin
                        // issue the child lookup, forward a pending parent write
                        busy_next     = 1'b1;
                        rd_addr_next  = bit_in ? cl_reg : cf_reg;
                        fwd_hit_next  = pend_we_reg && (pend_addr_reg == rd_addr_next);
                        fwd_data_next = pend_data_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // add a child to the node on top of the stack
        if (do_add)
        begin
            add_fail = (nc_next >= NC_W'(MAX_NODES)) || (sp_next == '0)
                || (sp_next > SP_W'(STACK_DEPTH))
                || (add_push && sp_next >= SP_W'(STACK_DEPTH));
            if (add_fail)
            begin
                stop_f  = 1'b1;
                stop_st = ST_MAL;
            end
            else
            begin
                new_node       = nc_next[NODE_W-1:0];
                par_first      = (top_next.first == '0) ? new_node : top_next.first;
                add_we         = 1'b1;
                add_addr       = new_node;
                add_data       = '{value: add_val, first: '0, last: '0};
                pend_we_next   = 1'b1;
                pend_addr_next = top_next.node;
                pend_data_next = '{value: 8'd0, first: par_first, last: new_node};
                if (top_next.node == '0)
                    rf_next = par_first;
                else if (top_next.node == rf_reg)
                begin
                    sf_next = par_first;
                    sl_next = new_node;
                end
                top_next.first = par_first;
                nc_next        = nc_next + NC_W'(1);
                if (add_push)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_m1[STK_AW-1:0];
                    stk_wdata = top_next;
                    top_next  = '{node: new_node, first: '0};
                    sp_next   = sp_next + SP_W'(1);
                end
                chk_tok = 1'b1;
            end
        end

        // token done: end of tree when count reached or root closed
        if (chk_tok && (sp_next == '0 || bits_next >= {1'b0, tree_cnt_reg}))
            chk_end = 1'b1;

        if (chk_end)
        begin
            stop_f = 1'b1;
            if (bits_next != {1'b0, tree_cnt_reg})
                stop_st = ST_SIZE;
            else if (rf_next == '0 || sf_next == '0)
                stop_st = ST_MAL;
            else
            begin
                phase_next = PH_DATA;
                cf_next    = sf_next;
                cl_next    = sl_next;
                bits_next  = '0;
                stop_f     = (data_cnt_reg == 32'd0);
                stop_st    = ST_OK;
            end
        end

        if (stop_f)
            phase_next = PH_DONE;

        // result item
        push             = stop_f || sym_v;
        res.symbol       = sym;
        res.symbol_valid = sym_v;
        res.done_res     = stop_f;
        res.status       = stop_f ? stop_st : ST_OK;
        res.out_count    = bytes_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            sp_reg        <= '0;
            nc_reg        <= NC_W'(1);
            bits_reg      <= '0;
            sh_reg        <= '0;
            idx_reg       <= '0;
            bytes_reg     <= '0;
            top_reg       <= '0;
            top_load_reg  <= 1'b0;
            rf_reg        <= '0;
            sf_reg        <= '0;
            sl_reg        <= '0;
            cf_reg        <= '0;
            cl_reg        <= '0;
            busy_reg      <= 1'b0;
            rd_addr_reg   <= '0;
            fwd_hit_reg   <= 1'b0;
            fwd_data_reg  <= '0;
            pend_we_reg   <= 1'b0;
            pend_addr_reg <= '0;
            pend_data_reg <= '0;
            tree_cnt_reg  <= '0;
            data_cnt_reg  <= '0;
            cap_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sp_reg        <= sp_next;
            nc_reg        <= nc_next;
            bits_reg      <= bits_next;
            sh_reg        <= sh_next;
            idx_reg       <= idx_next;
            bytes_reg     <= bytes_next;
            top_reg       <= top_next;
            top_load_reg  <= top_load_next;
            rf_reg        <= rf_next;
            sf_reg        <= sf_next;
            sl_reg        <= sl_next;
            cf_reg        <= cf_next;
            cl_reg        <= cl_next;
            busy_reg      <= busy_next;
            rd_addr_reg   <= rd_addr_next;
            fwd_hit_reg   <= fwd_hit_next;
            fwd_data_reg  <= fwd_data_next;
            pend_we_reg   <= pend_we_next;
            pend_addr_reg <= pend_addr_next;
            pend_data_reg <= pend_data_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_TREE)
                    tree_cnt_reg <= cfg_data;
                if (cfg_index == CFG_DATA)
                    data_cnt_reg <= cfg_data;
                if (cfg_index == CFG_CAP)
                    cap_reg <= cfg_data;
            end
        end
    end

    // node store: new node now, parent links in the next cycle
    assign mem_we    = pend_we_reg || add_we;
    assign mem_waddr = pend_we_reg ? pend_addr_reg : add_addr;
    assign mem_wdata = pend_we_reg ? pend_data_reg : add_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            node_mem[mem_waddr] <= mem_wdata;
        node_rdata_reg <= node_mem[rd_addr_next];
    end

    // node stack below the cached top entry
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    `HTS_ASSERT_NEXT(a_lookup_one_cycle, busy_reg, !busy_reg, "node lookup longer than a cycle")
    `HTS_ASSERT_IMPL(a_single_write, pend_we_reg, !add_we, "two node writes in one cycle")
    `HTS_ASSERT_TRUE(a_sp_range, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer out of range")

endmodule
`default_nettype wire

### sv/huffman_tree_stream_decoder.sv
// channel | signals                        | direction | accepted when
// in      | in_valid in_ready bit_in first | in        | in_valid & in_ready
// out     | out_valid out_ready symbol ... | out       | out_valid & out_ready
// cfg     | cfg_valid cfg_ready idx data   | in        | cfg_valid & cfg_ready
//
// tree bits are accepted while the output queue has room; a data bit stalls the input
// for the node store read that each walk step needs before the next bit
// a two-item output queue lets input run while a result waits
// rst_n clears control state at once; no clearing pass over the memories
// input stalls only during a data lookup or with the output queue full
`default_nettype none
module huffman_tree_stream_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        bit_in,
    input  wire logic        first,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       symbol,
    output logic             symbol_valid,
    output logic             done_res,
    output logic [2:0]       status,
    output logic [31:0]      out_count
);
    import hts_pkg::*;

    logic    core_busy, core_push, room;
    result_t core_res, q_res;

    assign in_ready  = !core_busy && room;
    assign cfg_ready = 1'b1;

    // decode engine
    hts_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_valid && in_ready),
        .bit_in    (bit_in),
        .first     (first),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (core_busy),
        .push      (core_push),
        .res       (core_res)
    );

    // result queue
    hts_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_push),
        .push_data (core_res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (q_res)
    );

    assign symbol       = q_res.symbol;
    assign symbol_valid = q_res.symbol_valid;
    assign done_res     = q_res.done_res;
    assign status       = q_res.status;
    assign out_count    = q_res.out_count;

endmodule
`default_nettype wire
